### hw/rtl/srtf_pkg.sv
// srtf_pkg: types and constants shared by the srtf tick scheduler files
// no dependencies; compile first

package srtf_pkg;

  localparam int TIME_W  = 21;
  localparam int SUM_W   = 25;
  localparam int VAL_W   = 16;
  localparam int ENTRY_W = 4;
  localparam int CNT_W   = 5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_STAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               command;
    logic [ENTRY_W-1:0] entry_index;
    logic [VAL_W-1:0]   arrival_in;
    logic [VAL_W-1:0]   burst_in;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]  tick_time;
    logic               ran;
    logic [ENTRY_W-1:0] running_index;
    logic               first_run;
    logic               finished;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  turn_span;
    logic [TIME_W-1:0]  wait_span;
    logic               all_done;
    logic [SUM_W-1:0]   total_turnaround;
    logic [SUM_W-1:0]   total_waiting;
  } out_word_t;

  typedef logic [CNT_W-1:0] cfg_word_t;

  // entry write broadcast to the cell row
  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] index;
    logic [VAL_W-1:0]   arrival;
    logic [VAL_W-1:0]   burst;
  } load_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] arr;
    logic [VAL_W-1:0] burst;
  } cand_t;

endpackage

### hw/rtl/srtf_chan_if.sv
// srtf_chan_if: valid/ready channel carrying one word of a chosen type
// depends on nothing; word types come from srtf_pkg at the instance

interface srtf_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/srtf_cell.sv
// srtf_cell: one process entry of the scheduler row plus its compare stage
// depends on srtf_pkg

module srtf_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srtf_pkg::load_t                ld,
  input  logic                           run_valid,
  input  logic [IDX_W-1:0]               run_idx,
  input  logic [srtf_pkg::TIME_W-1:0]    now,
  input  logic [srtf_pkg::CNT_W-1:0]     active_count,
  input  srtf_pkg::cand_t                cand_in,
  input  logic [IDX_W-1:0]               idx_in,
  output srtf_pkg::cand_t                cand_out,
  output logic [IDX_W-1:0]               idx_out,
  output logic                           settled
);

  logic [srtf_pkg::VAL_W-1:0] arr_r;
  logic [srtf_pkg::VAL_W-1:0] burst_r;
  logic [srtf_pkg::VAL_W-1:0] rem_r;
  logic                       done_r;
  srtf_pkg::cand_t            cand_r;
  logic [IDX_W-1:0]           idx_r;

  logic in_use;
  logic load_hit;
  logic run_hit;
  logic eligible;
  logic better;

  assign in_use   = INDEX < int'(active_count);
  assign load_hit = ld.valid && (int'(ld.index) == INDEX);
  assign run_hit  = run_valid && (run_idx == IDX_W'(INDEX));
  assign eligible = in_use && !done_r &&
                    ({{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, arr_r} <= now);
  assign better   = !cand_in.valid || (rem_r < cand_in.rem) ||
                    ((rem_r == cand_in.rem) && (arr_r < cand_in.arr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (load_hit) begin
      done_r <= 1'b0;
    end else if (run_hit && (rem_r <= srtf_pkg::VAL_W'(1))) begin
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      arr_r   <= ld.arrival;
      burst_r <= ld.burst;
      rem_r   <= ld.burst;
    end else if (run_hit) begin
      if (rem_r <= srtf_pkg::VAL_W'(1)) begin
        rem_r <= '0;
      end else begin
        rem_r <= rem_r - srtf_pkg::VAL_W'(1);
      end
    end
    if (eligible && better) begin
      cand_r <= '{valid: 1'b1, rem: rem_r, arr: arr_r, burst: burst_r};
      idx_r  <= IDX_W'(INDEX);
    end else begin
      cand_r <= cand_in;
      idx_r  <= idx_in;
    end
  end

  assign cand_out = cand_r;
  assign idx_out  = idx_r;
  assign settled  = done_r || !in_use;

endmodule

### hw/rtl/srtf_tick_scheduler_unit.sv
// srtf_tick_scheduler_unit: top level of the shortest-remaining-time-first scheduler
// depends on srtf_pkg, srtf_chan_if and srtf_cell

// A load word is taken in IDLE and writes its entry at once. A tick word
// passes through SCAN, UPDATE, STAT and EMIT: the best candidate
// walks the row of entry cells one cell per cycle, then UPDATE updates the
// chosen entry, STAT forms the statistics and EMIT loads the result register
// once the previous result has been taken. The next word is taken in the cycle
// after that, even while the previous result is still waiting on the output side.
// Reset is synchronous, with no clearing pass.

module srtf_tick_scheduler_unit #(
  parameter int MAX_PROCS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  srtf_chan_if.sink    in_ch,
  srtf_chan_if.source  out_ch,
  srtf_chan_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_PROCS);

  srtf_pkg::state_t state_r, state_nxt;

  logic [srtf_pkg::CNT_W-1:0]  active_r;
  logic [srtf_pkg::TIME_W-1:0] now_r;
  logic [IDX_W-1:0]            cnt_r;
  logic [srtf_pkg::SUM_W-1:0]  sum_t_r;
  logic [srtf_pkg::SUM_W-1:0]  sum_w_r;

  logic                        ran_r;
  logic [IDX_W-1:0]            pick_r;
  logic                        first_r;
  logic                        fin_r;
  logic [srtf_pkg::VAL_W-1:0]  burst_r;
  logic [srtf_pkg::TIME_W-1:0] tick_r;
  logic [srtf_pkg::TIME_W-1:0] ct_r;
  logic [srtf_pkg::TIME_W-1:0] tat_r;
  logic [srtf_pkg::TIME_W-1:0] wt_r;

  srtf_pkg::out_word_t out_r;
  logic                out_valid_r;

  logic in_accept;
  logic run_valid;
  logic emit_fire;
  srtf_pkg::load_t ld;
  srtf_pkg::in_word_t in_w;

  srtf_pkg::cand_t  cand_chain [0:MAX_PROCS];
  logic [IDX_W-1:0] idx_chain  [0:MAX_PROCS];
  logic [MAX_PROCS-1:0] settled_vec;
  srtf_pkg::cand_t  tail;
  logic [31:0]      pick32;
  logic [srtf_pkg::TIME_W-1:0] t_next;

  assign in_w      = in_ch.data;
  assign in_ch.ready  = (state_r == srtf_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign ld.valid   = in_accept && (in_w.command == srtf_pkg::CMD_LOAD);
  assign ld.index   = in_w.entry_index;
  assign ld.arrival = in_w.arrival_in;
  assign ld.burst   = (in_w.burst_in == '0) ? srtf_pkg::VAL_W'(1) : in_w.burst_in;

  assign cand_chain[0] = '0;
  assign idx_chain[0]  = '0;
  assign tail          = cand_chain[MAX_PROCS];
  assign t_next        = srtf_pkg::TIME_W'(now_r + srtf_pkg::TIME_W'(1));

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    srtf_cell #(
      .INDEX (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ld           (ld),
      .run_valid    (run_valid),
      .run_idx      (idx_chain[MAX_PROCS]),
      .now          (now_r),
      .active_count (active_r),
      .cand_in      (cand_chain[g]),
      .idx_in       (idx_chain[g]),
      .cand_out     (cand_chain[g+1]),
      .idx_out      (idx_chain[g+1]),
      .settled      (settled_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srtf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    run_valid = 1'b0;
    emit_fire = 1'b0;
    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        if (in_accept && (in_w.command == srtf_pkg::CMD_TICK)) begin
          state_nxt = srtf_pkg::ST_SCAN;
        end
      end
      srtf_pkg::ST_SCAN: begin
        if (cnt_r == IDX_W'(MAX_PROCS - 1)) begin
          state_nxt = srtf_pkg::ST_UPDATE;
        end
      end
      srtf_pkg::ST_UPDATE: begin
        run_valid = tail.valid;
        state_nxt = srtf_pkg::ST_STAT;
      end
      srtf_pkg::ST_STAT: begin
        state_nxt = srtf_pkg::ST_EMIT;
      end
      srtf_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit_fire = 1'b1;
          state_nxt = srtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      now_r       <= '0;
      cnt_r       <= '0;
      sum_t_r     <= '0;
      sum_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        active_r <= cfg_ch.data;
      end
      if (state_r == srtf_pkg::ST_SCAN) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == srtf_pkg::ST_UPDATE) begin
        now_r <= t_next;
      end
      if ((state_r == srtf_pkg::ST_STAT) && fin_r) begin
        sum_t_r <= srtf_pkg::SUM_W'(sum_t_r + srtf_pkg::SUM_W'(tat_r));
      end
      if (emit_fire && fin_r) begin
        sum_w_r <= srtf_pkg::SUM_W'(sum_w_r + srtf_pkg::SUM_W'(wt_r));
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pick32 = 32'(pick_r);

  always_ff @(posedge clk) begin
    if (state_r == srtf_pkg::ST_UPDATE) begin
      tick_r  <= now_r;
      ran_r   <= tail.valid;
      pick_r  <= idx_chain[MAX_PROCS];
      first_r <= tail.valid && (tail.rem == tail.burst);
      fin_r   <= tail.valid && (tail.rem <= srtf_pkg::VAL_W'(1));
      burst_r <= tail.burst;
      ct_r    <= t_next;
      tat_r   <= srtf_pkg::TIME_W'(t_next - srtf_pkg::TIME_W'(tail.arr));
    end
    if (state_r == srtf_pkg::ST_STAT) begin
      wt_r <= srtf_pkg::TIME_W'(tat_r - srtf_pkg::TIME_W'(burst_r));
    end
    if (emit_fire) begin
      out_r.tick_time        <= tick_r;
      out_r.ran              <= ran_r;
      out_r.running_index    <= ran_r ? pick32[srtf_pkg::ENTRY_W-1:0] : '0;
      out_r.first_run        <= first_r;
      out_r.finished         <= fin_r;
      out_r.finish_time      <= fin_r ? ct_r : '0;
      out_r.turn_span        <= fin_r ? tat_r : '0;
      out_r.wait_span        <= fin_r ? wt_r : '0;
      out_r.all_done         <= &settled_vec;
      out_r.total_turnaround <= sum_t_r;
      out_r.total_waiting    <= fin_r ? srtf_pkg::SUM_W'(sum_w_r + srtf_pkg::SUM_W'(wt_r))
                                      : sum_w_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == srtf_pkg::ST_EMIT))
    else $error("result appeared outside emit");

  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srtf_pkg::ST_UPDATE) |=>
      (now_r == srtf_pkg::TIME_W'($past(now_r) + srtf_pkg::TIME_W'(1))))
    else $error("time did not advance by one on a tick");

  a_finish_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.finished || out_r.ran))
    else $error("finished without a run");
`endif

endmodule
